FILE: hw/rtl/mcc_pkg.sv
// ----------------------------------------------------------------------------
// mcc_pkg
// Shared types and constants for the mouse card controller.
// ----------------------------------------------------------------------------
package mcc_pkg;

    localparam int BUFFER_DEPTH_DEF   = 8;
    localparam int POSITION_WIDTH_DEF = 16;
    localparam int HOST_WIDTH         = 12;

    localparam logic [7:0] HS_MASK     = 8'h3E;
    localparam logic [7:0] OP_MASK     = 8'hF0;
    localparam logic [7:0] EV_KEEP     = 8'h20;
    localparam logic [7:0] EV_MOVE     = 8'h22;
    localparam logic [7:0] EV_SRC_MASK = 8'h0E;
    localparam logic [7:0] PORT_B_RST  = 8'h40;
    localparam int         CLAMP_DEF   = 1023;

    typedef enum logic [2:0] {
        CMD_PORT_A  = 3'd0,
        CMD_PORT_B  = 3'd1,
        CMD_MOVE    = 3'd2,
        CMD_BUTTON  = 3'd3,
        CMD_VBLANK  = 3'd4
    } t_cmd;

    typedef enum logic [3:0] {
        OP_MODE   = 4'h0,
        OP_READ   = 4'h1,
        OP_SERVE  = 4'h2,
        OP_CLEAR  = 4'h3,
        OP_SETPOS = 4'h4,
        OP_INIT   = 4'h5,
        OP_CLAMP  = 4'h6,
        OP_HOME   = 4'h7,
        OP_TIMING = 4'h9,
        OP_NOP2   = 4'hA
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_EVT,
        S_OUT
    } t_state;

    localparam logic CFG_RANGE_X = 1'b0;
    localparam logic CFG_RANGE_Y = 1'b1;

endpackage

FILE: hw/rtl/mcc_div.sv
// ----------------------------------------------------------------------------
// mcc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mcc_div #(
    parameter int DW = 32,
    parameter int VW = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);
    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW:0]   shifted;
    logic [VW:0]   diff;
    logic          ge;

    assign shifted    = {r_rem, r_quo[DW-1]};
    assign ge         = shifted >= {1'b0, i_divisor};
    assign diff       = shifted - {1'b0, i_divisor};
    assign o_done     = r_busy && (r_cnt == '0);
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DW);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy && r_cnt != '0) begin
            r_rem <= ge ? diff[VW-1:0] : shifted[VW-1:0];
            r_quo <= {r_quo[DW-2:0], ge};
        end
    end

endmodule

FILE: hw/rtl/mouse_card_controller_core.sv
// ----------------------------------------------------------------------------
// mouse_card_controller_core
// Mouse card controller: port A/B command protocol, scaled pointer position,
// clamp window, mode and interrupt status.
// Port words and a vblank word without a rising edge go straight to the result;
// button and vblank-rise words pass through an event step first; with nonzero
// ranges, a pointer move and a set-position strobe each run two divisions
// (x, then y) on the shared divider, and a pointer move then takes the event step.
// One word at a time; stall is high from acceptance until the result is taken,
// and the next word can be taken in the cycle after that.
// Reset (synchronous, active low) loads all state but the captured input word
// to its power-up values.
// ----------------------------------------------------------------------------
module mouse_card_controller_core #(
    parameter int BUFFER_DEPTH   = mcc_pkg::BUFFER_DEPTH_DEF,
    parameter int POSITION_WIDTH = mcc_pkg::POSITION_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [11:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_data_byte,
    input  logic [11:0] i_host_x,
    input  logic [11:0] i_host_y,
    input  logic        i_button_index,
    input  logic        i_button_down,
    input  logic        i_vblank_level,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_port_a_out,
    output logic [7:0]  o_port_b_out,
    output logic [2:0]  o_rom_page,
    output logic        o_irq_line
);
    import mcc_pkg::*;

    localparam int PW  = POSITION_WIDTH;
    localparam int BIW = $clog2(BUFFER_DEPTH);
    localparam int BPW = $clog2(BUFFER_DEPTH + 1);
    localparam int DW  = 16 + PW;
    localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

    t_state r_state, n_state;
    logic [2:0]  r_cmd;
    logic [7:0]  r_data;
    logic [11:0] r_hx, r_hy;
    logic        r_bi, r_bd, r_vb;
    logic [11:0] r_range_x, r_range_y;

    logic [7:0]    r_cpu_byte, n_cpu_byte;
    logic [7:0]    r_port_b, n_port_b;
    logic [7:0]    r_reply, n_reply;
    logic [7:0]    r_buf [BUFFER_DEPTH];
    logic [7:0]    n_buf [BUFFER_DEPTH];
    logic [BPW-1:0] r_buf_pos, n_buf_pos;
    logic [2:0]    r_msg_len, n_msg_len;
    logic [3:0]    r_mode, n_mode;
    logic [7:0]    r_status, n_status;
    logic [PW-1:0] r_pos_x, n_pos_x, r_pos_y, n_pos_y;
    logic [15:0]   r_read_x, n_read_x, r_read_y, n_read_y;
    logic [PW-1:0] r_cmin_x, n_cmin_x, r_cmax_x, n_cmax_x;
    logic [PW-1:0] r_cmin_y, n_cmin_y, r_cmax_y, n_cmax_y;
    logic [1:0]    r_btn_now, n_btn_now, r_btn_seen, n_btn_seen;
    logic          r_vb_prev, n_vb_prev, r_irq, n_irq;
    logic          r_axis, n_axis, r_evt, n_evt;
    logic [15:0]   r_opx, n_opx, r_opy, n_opy;

    logic          div_start, div_done;
    logic [DW-1:0] div_dividend, div_quo;
    logic [11:0]   div_divisor;

    function automatic logic [PW-1:0] sat16(input logic [15:0] v);
        logic [15:0] lim;
        lim = 16'(POS_MAX);
        return (v > lim) ? POS_MAX : PW'(v);
    endfunction

    assign o_cfg_ready  = 1'b1;
    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = (r_state == S_OUT);
    assign o_port_a_out = r_reply;
    assign o_port_b_out = r_port_b;
    assign o_rom_page   = r_port_b[3:1];
    assign o_irq_line   = r_irq;

    assign div_divisor  = r_axis ? r_range_y : r_range_x;

    mcc_div #(.DW(DW), .VW(12)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_x <= '0;
            r_range_y <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_RANGE_X) begin
                r_range_x <= i_cfg_data;
            end else begin
                r_range_y <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_cmd  <= i_command;
            r_data <= i_data_byte;
            r_hx   <= i_host_x;
            r_hy   <= i_host_y;
            r_bi   <= i_button_index;
            r_bd   <= i_button_down;
            r_vb   <= i_vblank_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cpu_byte <= '0;
            r_port_b   <= PORT_B_RST;
            r_reply    <= '0;
            for (int i = 0; i < BUFFER_DEPTH; i++) r_buf[i] <= '0;
            r_buf_pos  <= '0;
            r_msg_len  <= 3'd1;
            r_mode     <= '0;
            r_status   <= '0;
            r_pos_x    <= '0;
            r_pos_y    <= '0;
            r_read_x   <= '0;
            r_read_y   <= '0;
            r_cmin_x   <= '0;
            r_cmax_x   <= PW'(CLAMP_DEF);
            r_cmin_y   <= '0;
            r_cmax_y   <= PW'(CLAMP_DEF);
            r_btn_now  <= '0;
            r_btn_seen <= '0;
            r_vb_prev  <= 1'b0;
            r_irq      <= 1'b0;
            r_axis     <= 1'b0;
            r_evt      <= 1'b0;
            r_opx      <= '0;
            r_opy      <= '0;
        end else begin
            r_state    <= n_state;
            r_cpu_byte <= n_cpu_byte;
            r_port_b   <= n_port_b;
            r_reply    <= n_reply;
            r_buf      <= n_buf;
            r_buf_pos  <= n_buf_pos;
            r_msg_len  <= n_msg_len;
            r_mode     <= n_mode;
            r_status   <= n_status;
            r_pos_x    <= n_pos_x;
            r_pos_y    <= n_pos_y;
            r_read_x   <= n_read_x;
            r_read_y   <= n_read_y;
            r_cmin_x   <= n_cmin_x;
            r_cmax_x   <= n_cmax_x;
            r_cmin_y   <= n_cmin_y;
            r_cmax_y   <= n_cmax_y;
            r_btn_now  <= n_btn_now;
            r_btn_seen <= n_btn_seen;
            r_vb_prev  <= n_vb_prev;
            r_irq      <= n_irq;
            r_axis     <= n_axis;
            r_evt      <= n_evt;
            r_opx      <= n_opx;
            r_opy      <= n_opy;
        end
    end

    always_comb begin
        logic [7:0]    diff;
        logic [7:0]    ev;
        logic [3:0]    op;
        logic [PW-1:0] lo, hi;
        logic          need_div;
        logic          zero_range;

        n_state    = r_state;
        n_cpu_byte = r_cpu_byte;
        n_port_b   = r_port_b;
        n_reply    = r_reply;
        n_buf      = r_buf;
        n_buf_pos  = r_buf_pos;
        n_msg_len  = r_msg_len;
        n_mode     = r_mode;
        n_status   = r_status;
        n_pos_x    = r_pos_x;
        n_pos_y    = r_pos_y;
        n_read_x   = r_read_x;
        n_read_y   = r_read_y;
        n_cmin_x   = r_cmin_x;
        n_cmax_x   = r_cmax_x;
        n_cmin_y   = r_cmin_y;
        n_cmax_y   = r_cmax_y;
        n_btn_now  = r_btn_now;
        n_btn_seen = r_btn_seen;
        n_vb_prev  = r_vb_prev;
        n_irq      = r_irq;
        n_axis     = r_axis;
        n_evt      = r_evt;
        n_opx      = r_opx;
        n_opy      = r_opy;
        div_start  = 1'b0;
        div_dividend = r_axis ? DW'(r_opy) * DW'(r_cmax_y) : DW'(r_opx) * DW'(r_cmax_x);
        diff       = '0;
        ev         = '0;
        op         = '0;
        lo         = '0;
        hi         = '0;
        need_div   = 1'b0;
        zero_range = (r_range_x == '0) || (r_range_y == '0);

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_state = S_OUT;
                n_axis  = 1'b0;
                n_evt   = 1'b0;
                case (r_cmd)
                    CMD_PORT_A: begin
                        n_cpu_byte = r_data;
                    end
                    CMD_PORT_B: begin
                        diff = (r_port_b ^ r_data) & HS_MASK;
                        if (diff != '0) begin
                            n_port_b = (r_port_b & ~HS_MASK) | (r_data & HS_MASK);
                            if (diff[5]) begin
                                if (r_data[5]) begin
                                    n_port_b[7] = 1'b1;
                                end else begin
                                    if (n_buf_pos < BPW'(BUFFER_DEPTH)) begin
                                        n_buf[n_buf_pos[BIW-1:0]] = r_cpu_byte;
                                    end
                                    n_buf_pos = n_buf_pos + 1'b1;
                                    // first byte in: decode the command
                                    if (n_buf_pos == BPW'(1)) begin
                                        op = n_buf[0][7:4];
                                        case (op)
                                            OP_MODE: begin
                                                n_msg_len = 3'd1;
                                                n_mode    = n_buf[0][3:0];
                                            end
                                            OP_READ: begin
                                                n_msg_len = 3'd6;
                                                n_status  = n_status & EV_KEEP;
                                                n_read_x  = 16'(n_pos_x);
                                                n_read_y  = 16'(n_pos_y);
                                                if (n_btn_seen[0]) n_status[6] = 1'b1;
                                                if (n_btn_seen[1]) n_status[0] = 1'b1;
                                                n_btn_seen = n_btn_now;
                                                if (n_btn_seen[0]) n_status[7] = 1'b1;
                                                if (n_btn_seen[1]) n_status[4] = 1'b1;
                                                n_buf[1] = n_read_x[7:0];
                                                n_buf[2] = n_read_x[15:8];
                                                n_buf[3] = n_read_y[7:0];
                                                n_buf[4] = n_read_y[15:8];
                                                n_buf[5] = n_status;
                                                n_status = n_status & ~EV_KEEP;
                                            end
                                            OP_SERVE: begin
                                                n_msg_len = 3'd2;
                                                n_buf[1]  = n_status & ~EV_KEEP;
                                                n_irq     = 1'b0;
                                            end
                                            OP_CLEAR: begin
                                                n_buf_pos  = '0;
                                                n_msg_len  = 3'd1;
                                                n_mode     = '0;
                                                n_status   = '0;
                                                n_read_x   = '0;
                                                n_read_y   = '0;
                                                n_btn_seen = '0;
                                                n_cmin_x   = '0;
                                                n_cmax_x   = PW'(CLAMP_DEF);
                                                n_cmin_y   = '0;
                                                n_cmax_y   = PW'(CLAMP_DEF);
                                                n_pos_x    = '0;
                                                n_pos_y    = '0;
                                            end
                                            OP_SETPOS, OP_CLAMP: begin
                                                n_msg_len = 3'd5;
                                            end
                                            OP_INIT: begin
                                                n_msg_len = 3'd3;
                                                n_buf[1]  = 8'hFF;
                                            end
                                            OP_TIMING: begin
                                                case (n_buf[0][3:2])
                                                    2'd1:    n_msg_len = 3'd3;
                                                    2'd2:    n_msg_len = 3'd2;
                                                    2'd3:    n_msg_len = 3'd4;
                                                    default: n_msg_len = 3'd1;
                                                endcase
                                            end
                                            OP_HOME: begin
                                                n_msg_len = 3'd1;
                                                if (zero_range) begin
                                                    n_pos_x  = n_cmin_x;
                                                    n_pos_y  = n_cmin_y;
                                                    n_read_x = 16'(n_cmin_x);
                                                    n_read_y = 16'(n_cmin_y);
                                                end else begin
                                                    n_pos_x = '0;
                                                    n_pos_y = '0;
                                                end
                                            end
                                            OP_NOP2: begin
                                                n_msg_len = 3'd2;
                                            end
                                            default: begin
                                                n_msg_len = 3'd1;
                                            end
                                        endcase
                                        n_reply = n_buf[1];
                                    end
                                    // last byte in: act on the command
                                    if (n_buf_pos == BPW'(n_msg_len) ||
                                        n_buf_pos > BPW'(BUFFER_DEPTH - 1)) begin
                                        op = n_buf[0][7:4];
                                        case (op)
                                            OP_CLAMP: begin
                                                lo = sat16({n_buf[3], n_buf[1]});
                                                hi = sat16({n_buf[4], n_buf[2]});
                                                if (lo <= hi) begin
                                                    if (n_buf[0][0]) begin
                                                        n_cmin_y = lo;
                                                        n_cmax_y = hi;
                                                        if (n_pos_y > hi) n_pos_y = hi;
                                                        else if (n_pos_y < lo) n_pos_y = lo;
                                                    end else begin
                                                        n_cmin_x = lo;
                                                        n_cmax_x = hi;
                                                        if (n_pos_x > hi) n_pos_x = hi;
                                                        else if (n_pos_x < lo) n_pos_x = lo;
                                                    end
                                                end
                                            end
                                            OP_SETPOS: begin
                                                n_read_x = {n_buf[2], n_buf[1]};
                                                n_read_y = {n_buf[4], n_buf[3]};
                                                if (zero_range) begin
                                                    n_pos_x  = n_cmin_x;
                                                    n_pos_y  = n_cmin_y;
                                                    n_read_x = 16'(n_cmin_x);
                                                    n_read_y = 16'(n_cmin_y);
                                                end else begin
                                                    n_opx    = n_read_x;
                                                    n_opy    = n_read_y;
                                                    need_div = 1'b1;
                                                end
                                            end
                                            OP_INIT: begin
                                                n_read_x = '0;
                                                n_read_y = '0;
                                                n_cmin_x = '0;
                                                n_cmax_x = PW'(CLAMP_DEF);
                                                n_cmin_y = '0;
                                                n_cmax_y = PW'(CLAMP_DEF);
                                                n_pos_x  = '0;
                                                n_pos_y  = '0;
                                            end
                                            default: begin
                                            end
                                        endcase
                                        n_buf_pos = '0;
                                    end
                                    n_port_b[7] = 1'b0;
                                end
                            end
                            if (diff[4]) begin
                                if (r_data[4]) begin
                                    n_port_b[6] = 1'b0;
                                end else begin
                                    if (n_buf_pos != '0) n_buf_pos = n_buf_pos + 1'b1;
                                    if (n_buf_pos == BPW'(n_msg_len) ||
                                        n_buf_pos > BPW'(BUFFER_DEPTH - 1)) begin
                                        n_buf_pos = '0;
                                    end else begin
                                        n_reply = n_buf[n_buf_pos[BIW-1:0]];
                                    end
                                    n_port_b[6] = 1'b1;
                                end
                            end
                        end
                        if (need_div) n_state = S_MUL;
                    end
                    CMD_MOVE: begin
                        if (zero_range) begin
                            n_pos_x  = r_cmin_x;
                            n_pos_y  = r_cmin_y;
                            n_read_x = 16'(r_cmin_x);
                            n_read_y = 16'(r_cmin_y);
                            n_state  = S_EVT;
                        end else begin
                            n_opx   = 16'(r_hx);
                            n_opy   = 16'(r_hy);
                            n_evt   = 1'b1;
                            n_state = S_MUL;
                        end
                    end
                    CMD_BUTTON: begin
                        n_btn_now[r_bi] = r_bd;
                        n_state = S_EVT;
                    end
                    CMD_VBLANK: begin
                        if (r_vb != r_vb_prev) begin
                            n_vb_prev = r_vb;
                            if (r_vb) n_state = S_EVT;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            S_MUL: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end

            S_DIV: begin
                if (div_done) begin
                    if (r_axis) begin
                        n_pos_y = (|div_quo[DW-1:PW]) ? POS_MAX : div_quo[PW-1:0];
                        n_state = r_evt ? S_EVT : S_OUT;
                    end else begin
                        n_pos_x = (|div_quo[DW-1:PW]) ? POS_MAX : div_quo[PW-1:0];
                        n_axis  = 1'b1;
                        n_state = S_MUL;
                    end
                end
            end

            S_EVT: begin
                if (r_mode[0]) begin
                    if (r_read_x != 16'(r_pos_x) || r_read_y != 16'(r_pos_y)) ev = ev | EV_MOVE;
                    if (r_btn_seen != r_btn_now) ev[2] = 1'b1;
                    if (r_vb_prev) ev[3] = 1'b1;
                    ev = ev & ({4'h0, r_mode[3:1], 1'b0} | EV_KEEP);
                    if ((ev & EV_SRC_MASK) != '0) begin
                        n_status = r_status | ev;
                        n_irq    = 1'b1;
                    end
                end
                n_state = S_OUT;
            end

            S_OUT: begin
                if (!i_stall) n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: verif/mcc_checker.sv
// ----------------------------------------------------------------------------
// mcc_checker
// Watches the input, result and register channels of the mouse card
// controller, predicts each result word from its own copy of the state and
// compares field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module mcc_checker
    import mcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [11:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_stall,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_data_byte,
    input  logic [11:0] i_host_x,
    input  logic [11:0] i_host_y,
    input  logic        i_button_index,
    input  logic        i_button_down,
    input  logic        i_vblank_level,
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic [7:0]  i_port_a_out,
    input  logic [7:0]  i_port_b_out,
    input  logic [2:0]  i_rom_page,
    input  logic        i_irq_line,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);

    localparam int BD = BUFFER_DEPTH_DEF;
    localparam int PW = POSITION_WIDTH_DEF;
    localparam logic [31:0] POS_MAX = (32'd1 << PW) - 1;

    typedef struct packed {
        logic [7:0] port_a;
        logic [7:0] port_b;
        logic [2:0] page;
        logic       irq;
    } t_port_word;

    t_port_word port_words_due[$];

    logic [11:0] range_x, range_y;
    logic [7:0]  cpu_byte, port_b, reply;
    logic [7:0]  msg [BD];
    logic [31:0] buf_pos, msg_len;
    logic [3:0]  mode;
    logic [7:0]  status;
    logic [31:0] pos_x, pos_y, read_x, read_y;
    logic [31:0] cmin_x, cmax_x, cmin_y, cmax_y;
    logic [1:0]  btn_now, btn_seen;
    logic        vb_prev, irq;

    function automatic logic [31:0] sat_pos(logic [63:0] v);
        return (v > POS_MAX) ? POS_MAX : v[31:0];
    endfunction

    task automatic set_clamp(bit is_y, logic [31:0] lo_in, logic [31:0] hi_in);
        logic [31:0] lo, hi;
        lo = sat_pos(lo_in);
        hi = sat_pos(hi_in);
        if (lo > hi) return;
        if (is_y) begin
            cmin_y = lo; cmax_y = hi;
            if (pos_y > hi) pos_y = hi;
            else if (pos_y < lo) pos_y = lo;
        end else begin
            cmin_x = lo; cmax_x = hi;
            if (pos_x > hi) pos_x = hi;
            else if (pos_x < lo) pos_x = lo;
        end
    endtask

    task automatic place_pointer(logic [31:0] x, logic [31:0] y);
        if (range_x == 0 || range_y == 0) begin
            pos_x = cmin_x; read_x = cmin_x;
            pos_y = cmin_y; read_y = cmin_y;
            return;
        end
        pos_x = sat_pos(64'(x) * 64'(cmax_x) / 64'(range_x));
        pos_y = sat_pos(64'(y) * 64'(cmax_y) / 64'(range_y));
    endtask

    task automatic home_defaults();
        read_x = 0; read_y = 0;
        set_clamp(0, 0, CLAMP_DEF);
        set_clamp(1, 0, CLAMP_DEF);
        place_pointer(0, 0);
    endtask

    task automatic raise_event();
        logic [7:0] ev;
        ev = 0;
        if (!mode[0]) return;
        if (read_x != pos_x || read_y != pos_y) ev |= EV_MOVE;
        if (btn_seen != btn_now) ev |= 8'h04;
        if (vb_prev) ev |= 8'h08;
        ev &= ({4'h0, mode} & EV_SRC_MASK) | EV_KEEP;
        if ((ev & EV_SRC_MASK) != 0) begin
            status |= ev;
            irq = 1;
        end
    endtask

    task automatic begin_command();
        t_op op;
        op = t_op'(msg[0][7:4]);
        case (op)
            OP_MODE: begin
                msg_len = 1; mode = msg[0][3:0];
            end
            OP_READ: begin
                msg_len = 6;
                status &= EV_KEEP;
                read_x = pos_x; read_y = pos_y;
                if (btn_seen[0]) status |= 8'h40;
                if (btn_seen[1]) status |= 8'h01;
                btn_seen = btn_now;
                if (btn_seen[0]) status |= 8'h80;
                if (btn_seen[1]) status |= 8'h10;
                msg[1] = read_x[7:0]; msg[2] = read_x[15:8];
                msg[3] = read_y[7:0]; msg[4] = read_y[15:8];
                msg[5] = status;
                status &= ~EV_KEEP;
            end
            OP_SERVE: begin
                msg_len = 2; msg[1] = status & ~EV_KEEP; irq = 0;
            end
            OP_CLEAR: begin
                buf_pos = 0; msg_len = 1; mode = 0; status = 0;
                btn_seen = 0;
                home_defaults();
            end
            OP_SETPOS, OP_CLAMP: msg_len = 5;
            OP_INIT: begin
                msg_len = 3; msg[1] = 8'hFF;
            end
            OP_TIMING: begin
                case (msg[0][3:2])
                    2'd1: msg_len = 3;
                    2'd2: msg_len = 2;
                    2'd3: msg_len = 4;
                    default: msg_len = 1;
                endcase
            end
            OP_HOME: begin
                msg_len = 1; place_pointer(0, 0);
            end
            OP_NOP2: msg_len = 2;
            default: msg_len = 1;
        endcase
        reply = msg[1];
    endtask

    task automatic finish_command();
        t_op op;
        op = t_op'(msg[0][7:4]);
        if (op == OP_CLAMP)
            set_clamp(msg[0][0], {msg[3], msg[1]}, {msg[4], msg[2]});
        else if (op == OP_SETPOS) begin
            read_x = {msg[2], msg[1]};
            read_y = {msg[4], msg[3]};
            place_pointer(read_x, read_y);
        end else if (op == OP_INIT)
            home_defaults();
    endtask

    task automatic write_port_b(logic [7:0] d);
        logic [7:0] diff;
        diff = (port_b ^ d) & HS_MASK;
        if (diff == 0) return;
        port_b = (port_b & ~HS_MASK) | (d & HS_MASK);
        if (diff[5]) begin
            if (d[5]) port_b[7] = 1;
            else begin
                if (buf_pos < BD) msg[buf_pos] = cpu_byte;
                buf_pos++;
                if (buf_pos == 1) begin_command();
                if (buf_pos == msg_len || buf_pos > BD - 1) begin
                    finish_command();
                    buf_pos = 0;
                end
                port_b[7] = 0;
            end
        end
        if (diff[4]) begin
            if (d[4]) port_b[6] = 0;
            else begin
                if (buf_pos != 0) buf_pos++;
                if (buf_pos == msg_len || buf_pos > BD - 1) buf_pos = 0;
                else reply = msg[buf_pos];
                port_b[6] = 1;
            end
        end
    endtask

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch %s: got %0h want %0h (word %0d)", what, got, want, o_results);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_port_word w;
        if (!i_rst_n) begin
            range_x = 0; range_y = 0;
            cpu_byte = 0; port_b = PORT_B_RST; reply = 0;
            foreach (msg[k]) msg[k] = 0;
            buf_pos = 0; msg_len = 1; mode = 0; status = 0;
            pos_x = 0; pos_y = 0; read_x = 0; read_y = 0;
            cmin_x = 0; cmax_x = CLAMP_DEF; cmin_y = 0; cmax_y = CLAMP_DEF;
            btn_now = 0; btn_seen = 0; vb_prev = 0; irq = 0;
            port_words_due.delete();
            o_errors = 0; o_results = 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_RANGE_X) range_x = i_cfg_data;
                else range_y = i_cfg_data;
            end
            if (i_res_valid && !i_res_stall) begin
                if (port_words_due.size() == 0) begin
                    $display("result word with nothing expected");
                    o_errors++;
                end else begin
                    w = port_words_due.pop_front();
                    if (i_port_a_out != w.port_a) report_mismatch("port_a", i_port_a_out, w.port_a);
                    if (i_port_b_out != w.port_b) report_mismatch("port_b", i_port_b_out, w.port_b);
                    if (i_rom_page != w.page) report_mismatch("rom_page", i_rom_page, w.page);
                    if (i_irq_line != w.irq) report_mismatch("irq", i_irq_line, w.irq);
                end
                o_results++;
            end
            if (i_valid && !i_stall) begin
                case (i_command)
                    CMD_PORT_A: cpu_byte = i_data_byte;
                    CMD_PORT_B: write_port_b(i_data_byte);
                    CMD_MOVE: begin
                        place_pointer(i_host_x, i_host_y);
                        raise_event();
                    end
                    CMD_BUTTON: begin
                        btn_now[i_button_index] = i_button_down;
                        raise_event();
                    end
                    CMD_VBLANK: begin
                        if (i_vblank_level != vb_prev) begin
                            vb_prev = i_vblank_level;
                            if (vb_prev) raise_event();
                        end
                    end
                    default: ;
                endcase
                w.port_a = reply; w.port_b = port_b;
                w.page = port_b[3:1]; w.irq = irq;
                port_words_due.push_back(w);
            end
            o_pending <= port_words_due.size();
        end
    end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the mouse card controller through directed command exchanges and
// randomized protocol traffic under several idle/stall mixes, with host
// range changes between phases; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import mcc_pkg::*;

    localparam int WATCHDOG = 20000;

    logic        i_clk = 0, i_rst_n = 0;
    logic        i_cfg_valid = 0, i_cfg_index = 0;
    logic [11:0] i_cfg_data = 0;
    logic        i_valid = 0, i_stall = 0;
    logic [2:0]  i_command = 0;
    logic [7:0]  i_data_byte = 0;
    logic [11:0] i_host_x = 0, i_host_y = 0;
    logic        i_button_index = 0, i_button_down = 0, i_vblank_level = 0;
    logic        o_cfg_ready, o_stall, o_valid, o_irq_line;
    logic [7:0]  o_port_a_out, o_port_b_out;
    logic [2:0]  o_rom_page;
    int          errors, pending, results;
    int          stall_pct = 0, idle_pct = 0, quiet = 0;
    logic [7:0]  pb_shadow = PORT_B_RST;

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    mouse_card_controller_core dut (.*);

    mcc_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index,
        .i_cfg_data, .i_valid, .i_stall(o_stall), .i_command, .i_data_byte,
        .i_host_x, .i_host_y, .i_button_index, .i_button_down, .i_vblank_level,
        .i_res_valid(o_valid), .i_res_stall(i_stall), .i_port_a_out(o_port_a_out),
        .i_port_b_out(o_port_b_out), .i_rom_page(o_rom_page), .i_irq_line(o_irq_line),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // receiver stall
    always @(posedge i_clk)
        i_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG) begin
            $display("** mouse_card_controller_core: FAILED **");
            $finish;
        end
    end

    task automatic send(t_cmd c, logic [7:0] d = 0, logic [11:0] hx = 0,
                        logic [11:0] hy = 0, logic bi = 0, logic bdn = 0, logic vb = 0);
        while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        i_valid <= 1; i_command <= c; i_data_byte <= d; i_host_x <= hx;
        i_host_y <= hy; i_button_index <= bi; i_button_down <= bdn;
        i_vblank_level <= vb;
        do @(posedge i_clk); while (o_stall);
        i_valid <= 0;
        if (c == CMD_PORT_B) pb_shadow = d;
    endtask

    // Host side of one byte in: port A, then strobe bit 5 high and low.
    task automatic put_byte(logic [7:0] b);
        send(CMD_PORT_A, b);
        send(CMD_PORT_B, pb_shadow | 8'h20);
        send(CMD_PORT_B, pb_shadow & ~8'h20);
    endtask

    task automatic get_byte();
        send(CMD_PORT_B, pb_shadow | 8'h10);
        send(CMD_PORT_B, pb_shadow & ~8'h10);
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [11:0] v);
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic rand_command();
        logic [3:0] op;
        int n;
        op = 4'($urandom_range(15));
        if ($urandom_range(3) != 0) op = 4'($urandom_range(7));
        put_byte({op, 4'($urandom)});
        n = int'($urandom_range(4));
        repeat (n) begin
            if ($urandom_range(1)) put_byte(8'($urandom));
            else get_byte();
        end
    endtask

    task automatic rand_item();
        case ($urandom_range(9))
            0, 1, 2, 3: rand_command();
            4: send(CMD_MOVE, 8'd0, 12'($urandom), 12'($urandom));
            5: send(CMD_BUTTON, 8'd0, 12'd0, 12'd0, 1'($urandom), 1'($urandom));
            6: send(CMD_VBLANK, 8'd0, 12'd0, 12'd0, 1'b0, 1'b0, 1'($urandom));
            7: send(CMD_PORT_B, 8'($urandom));
            8: send(t_cmd'(3'($urandom_range(7))), 8'($urandom), 12'($urandom),
                    12'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
            default: get_byte();
        endcase
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: extreme host ranges, then each command
        write_reg(CFG_RANGE_X, 12'hFFF);
        write_reg(CFG_RANGE_Y, 12'd1);
        put_byte({OP_MODE, 4'hF});
        send(CMD_MOVE, 8'd0, 12'hFFF, 12'hFFF);
        send(CMD_BUTTON, 8'd0, 12'd0, 12'd0, 1'b1, 1'b1);
        send(CMD_VBLANK, 8'd0, 12'd0, 12'd0, 1'b0, 1'b0, 1'b1);
        put_byte({OP_READ, 4'h0});
        repeat (5) get_byte();
        put_byte({OP_SERVE, 4'h0}); get_byte();
        put_byte({OP_CLAMP, 4'h1}); put_byte(8'hFF); put_byte(8'h00);
        put_byte(8'hFF); put_byte(8'hFF);
        put_byte({OP_CLAMP, 4'h0}); put_byte(8'h10); put_byte(8'h00);
        put_byte(8'h00); put_byte(8'h00);  // min above max
        put_byte({OP_SETPOS, 4'h0}); repeat (4) put_byte(8'hFF);
        put_byte({OP_HOME, 4'h0}); put_byte({OP_INIT, 4'h0});
        put_byte({OP_TIMING, 4'hC}); put_byte({OP_NOP2, 4'h0});
        put_byte({OP_CLEAR, 4'h0}); put_byte(8'hF0);
        send(t_cmd'(3'd7), 8'hFF, 12'hFFF, 12'hFFF, 1'b1, 1'b1, 1'b1);
        send(CMD_PORT_B, 8'hFF); send(CMD_PORT_B, 8'h00);
        drain();
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 76; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 76; end
                3: begin idle_pct = 25; stall_pct = 25; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            write_reg(CFG_RANGE_X, ph == 4 ? 12'd0 : 12'($urandom_range(1, 4095)));
            write_reg(CFG_RANGE_Y, ph == 2 ? 12'hFFF : 12'($urandom));
            for (int k = 0; k < 35; k++) begin
                rand_item();
                if (k == 17) drain();
            end
            drain();
        end
        stall_pct = 0;
        drain();
        if (errors == 0)
            $display("** mouse_card_controller_core: PASSED **");
        else
            $display("** mouse_card_controller_core: FAILED **");
        $finish;
    end

endmodule
